// ----- sv/buffered_uart_channel_fifos_defines.svh -----
// ============================================================================
// Assertion macros for the buffered UART channel FIFOs
// Short forms of the concurrent assertions used in the RTL. Each use expects
// clk and rst_n to be visible in the enclosing module.
// ============================================================================
`ifndef BUFFERED_UART_CHANNEL_FIFOS_DEFINES_SVH
`define BUFFERED_UART_CHANNEL_FIFOS_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define BUC_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define BUC_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- sv/buc_pkg.sv -----
// ============================================================================
// Buffered UART channel FIFOs package
// Depths, field widths, event codes and the result record shared by the
// interfaces, the controller and the top level.
// ============================================================================
package buc_pkg;

    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);

    localparam int KIND_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 6;
    localparam int LOST_W  = 16;

    // Wide enough for any fill count and for the largest reportable level.
    localparam int CNT_W = ((RX_AW > TX_AW) ? ((RX_AW > LEVEL_W) ? RX_AW : LEVEL_W)
                                            : ((TX_AW > LEVEL_W) ? TX_AW : LEVEL_W)) + 1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [LOST_W-1:0]  LOST_MAX  = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LINE_IN     = 3'd0,
        KIND_HOST_READ   = 3'd1,
        KIND_HOST_WRITE  = 3'd2,
        KIND_LINE_READY  = 3'd3,
        KIND_RESET_COUNT = 3'd4
    } kind_t;

    typedef struct packed {
        logic               popped;
        logic               from_tx;
        logic               accepted;
        logic [LEVEL_W-1:0] rx_readable;
        logic [LEVEL_W-1:0] tx_writable;
        logic [LOST_W-1:0]  lost_count;
    } res_t;

    function automatic logic [LEVEL_W-1:0] sat_level(input logic [CNT_W-1:0] v);
        return (v > CNT_W'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
    endfunction

endpackage

// ----- sv/buc_req_if.sv -----
// ============================================================================
// Event channel
// Valid/ready channel that carries one event item into the block.
// ============================================================================
interface buc_req_if;
    import buc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, kind, data_byte, input ready);
    modport sink   (input valid, kind, data_byte, output ready);
endinterface

// ----- sv/buc_rsp_if.sv -----
// ============================================================================
// Result channel
// Valid/ready channel that carries one result item out of the block.
// ============================================================================
interface buc_rsp_if;
    import buc_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               out_valid;
    logic               accepted;
    logic [LEVEL_W-1:0] rx_readable;
    logic [LEVEL_W-1:0] tx_writable;
    logic [LOST_W-1:0]  lost_count;

    modport source (output valid, out_byte, out_valid, accepted, rx_readable,
                    tx_writable, lost_count, input ready);
    modport sink   (input valid, out_byte, out_valid, accepted, rx_readable,
                    tx_writable, lost_count, output ready);
endinterface

// ----- sv/buc_ram.sv -----
// ============================================================================
// Ring storage
// Simple dual-port RAM: one write port and one read port with registered
// read data that holds until the next read.
// ============================================================================
module buc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/buc_ctrl.sv -----
// ============================================================================
// Ring controller
// Decodes each event, moves the ring pointers and fill counts, keeps the
// lost-byte counter and holds the result record until it is taken.
// ============================================================================
`include "buffered_uart_channel_fifos_defines.svh"

module buc_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [buc_pkg::KIND_W-1:0] kind,
    input  logic [buc_pkg::BYTE_W-1:0] data_byte,
    output logic                     res_valid,
    input  logic                     res_ready,
    output buc_pkg::res_t            res,
    output logic                     rx_we,
    output logic [buc_pkg::RX_AW-1:0] rx_waddr,
    output logic [buc_pkg::BYTE_W-1:0] wdata,
    output logic                     rx_re,
    output logic [buc_pkg::RX_AW-1:0] rx_raddr,
    output logic                     tx_we,
    output logic [buc_pkg::TX_AW-1:0] tx_waddr,
    output logic                     tx_re,
    output logic [buc_pkg::TX_AW-1:0] tx_raddr
);
    import buc_pkg::*;

    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    logic [RX_AW-1:0]  rx_put_reg, rx_put_next;
    logic [RX_AW-1:0]  rx_take_reg, rx_take_next;
    logic [RX_AW-1:0]  rx_count_reg, rx_count_next;
    logic [TX_AW-1:0]  tx_put_reg, tx_put_next;
    logic [TX_AW-1:0]  tx_take_reg, tx_take_next;
    logic [TX_AW-1:0]  tx_count_reg, tx_count_next;
    logic [LOST_W-1:0] lost_reg, lost_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;
    logic              in_fire;
    kind_t             kind_code;
    logic              popped, from_tx, acc;

    assign kind_code = kind_t'(kind);

    // The result register frees up in the same cycle that its item is taken.
    assign in_ready = !res_valid_reg || res_ready;
    assign in_fire  = in_valid && in_ready;

    assign rx_waddr = rx_put_reg;
    assign rx_raddr = rx_take_reg;
    assign tx_waddr = tx_put_reg;
    assign tx_raddr = tx_take_reg;
    assign wdata    = data_byte;

    always_comb
    begin
        rx_put_next   = rx_put_reg;
        rx_take_next  = rx_take_reg;
        rx_count_next = rx_count_reg;
        tx_put_next   = tx_put_reg;
        tx_take_next  = tx_take_reg;
        tx_count_next = tx_count_reg;
        lost_next     = lost_reg;
        rx_we         = 1'b0;
        rx_re         = 1'b0;
        tx_we         = 1'b0;
        tx_re         = 1'b0;
        popped        = 1'b0;
        from_tx       = 1'b0;
        acc           = 1'b0;
        if (in_fire)
        begin
            unique case (kind_code)
                KIND_LINE_IN:
                begin
                    if (rx_count_reg == RX_LAST)
                    begin
                        if (lost_reg != LOST_MAX)
                        begin
                            lost_next = lost_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rx_we         = 1'b1;
                        rx_put_next   = (rx_put_reg == RX_LAST) ? '0 : rx_put_reg + 1'b1;
                        rx_count_next = rx_count_reg + 1'b1;
                        acc           = 1'b1;
                    end
                end
                KIND_HOST_READ:
                begin
                    if (rx_count_reg != '0)
                    begin
                        rx_re         = 1'b1;
                        rx_take_next  = (rx_take_reg == RX_LAST) ? '0 : rx_take_reg + 1'b1;
                        rx_count_next = rx_count_reg - 1'b1;
                        popped        = 1'b1;
                    end
                end
                KIND_HOST_WRITE:
                begin
                    if (tx_count_reg != TX_LAST)
                    begin
                        tx_we         = 1'b1;
                        tx_put_next   = (tx_put_reg == TX_LAST) ? '0 : tx_put_reg + 1'b1;
                        tx_count_next = tx_count_reg + 1'b1;
                        acc           = 1'b1;
                    end
                end
                KIND_LINE_READY:
                begin
                    if (tx_count_reg != '0)
                    begin
                        tx_re         = 1'b1;
                        tx_take_next  = (tx_take_reg == TX_LAST) ? '0 : tx_take_reg + 1'b1;
                        tx_count_next = tx_count_reg - 1'b1;
                        popped        = 1'b1;
                        from_tx       = 1'b1;
                    end
                end
                KIND_RESET_COUNT:
                begin
                    lost_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res_next.popped      = popped;
        res_next.from_tx     = from_tx;
        res_next.accepted    = acc;
        res_next.rx_readable = sat_level(CNT_W'(rx_count_next));
        res_next.tx_writable = sat_level(CNT_W'(TX_LAST - tx_count_next));
        res_next.lost_count  = lost_next;
    end

    always_comb
    begin
        if (in_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_put_reg    <= '0;
            rx_take_reg   <= '0;
            rx_count_reg  <= '0;
            tx_put_reg    <= '0;
            tx_take_reg   <= '0;
            tx_count_reg  <= '0;
            lost_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rx_put_reg    <= rx_put_next;
            rx_take_reg   <= rx_take_next;
            rx_count_reg  <= rx_count_next;
            tx_put_reg    <= tx_put_next;
            tx_take_reg   <= tx_take_next;
            tx_count_reg  <= tx_count_next;
            lost_reg      <= lost_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The fill counts must always agree with the distance between the pointers.
    `BUC_ASSERT(a_rx_count_gap, (int'(rx_put_reg) - int'(rx_take_reg) + ((rx_put_reg >= rx_take_reg) ? 0 : RX_DEPTH)) == int'(rx_count_reg), "rx fill count disagrees with pointers")
    `BUC_ASSERT(a_tx_count_gap, (int'(tx_put_reg) - int'(tx_take_reg) + ((tx_put_reg >= tx_take_reg) ? 0 : TX_DEPTH)) == int'(tx_count_reg), "tx fill count disagrees with pointers")
    `BUC_ASSERT(a_rx_bound, rx_count_reg <= RX_LAST, "rx ring holds more than its capacity")
    `BUC_ASSERT(a_tx_bound, tx_count_reg <= TX_LAST, "tx ring holds more than its capacity")
    `BUC_ASSERT_NEXT(a_lost_sticky, lost_reg == LOST_MAX && !(in_fire && kind_code == KIND_RESET_COUNT), lost_reg == LOST_MAX, "lost counter left saturation without a clear")

endmodule

// ----- sv/buffered_uart_channel_fifos.sv -----
// ============================================================================
// Buffered UART channel FIFOs
// Receive and transmit ring buffers of a UART channel with lost-byte count.
// ============================================================================
// Usage:
// Events arrive on the req channel (kind, data_byte) and each one answers with
// exactly one item on the rsp channel: a popped byte with out_valid, the
// accepted flag for pushes, the receive fill, the transmit free space and the
// saturating lost-byte count. Each ring holds its depth minus one bytes.
// The result is registered: an accepted item shows its result from the next
// cycle on. One item is taken every cycle while the receiver takes each
// result; the limit is the single write and single read port of each ring
// memory, and the pointer update that every event needs before the next one.
// While the receiver stalls the result is held, and req.ready stays low until
// the cycle in which the waiting result is taken.
// Reset clears the pointers, fill counts, lost-byte count and the result
// valid flag. The ring memories are not cleared; a pop only reads slots that
// an earlier push has written, so no clearing pass is needed.
// ============================================================================
module buffered_uart_channel_fifos (
    input logic        clk,
    input logic        rst_n,
    buc_req_if.sink    req,
    buc_rsp_if.source  rsp
);
    import buc_pkg::*;

    res_t              res;
    logic              res_valid;
    logic              rx_we, rx_re, tx_we, tx_re;
    logic [RX_AW-1:0]  rx_waddr, rx_raddr;
    logic [TX_AW-1:0]  tx_waddr, tx_raddr;
    logic [BYTE_W-1:0] wdata, rx_rdata, tx_rdata;

    buc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .kind      (req.kind),
        .data_byte (req.data_byte),
        .res_valid (res_valid),
        .res_ready (rsp.ready),
        .res       (res),
        .rx_we     (rx_we),
        .rx_waddr  (rx_waddr),
        .wdata     (wdata),
        .rx_re     (rx_re),
        .rx_raddr  (rx_raddr),
        .tx_we     (tx_we),
        .tx_waddr  (tx_waddr),
        .tx_re     (tx_re),
        .tx_raddr  (tx_raddr)
    );

    buc_ram #(.DEPTH(RX_DEPTH), .WIDTH(BYTE_W)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (wdata),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    buc_ram #(.DEPTH(TX_DEPTH), .WIDTH(BYTE_W)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (wdata),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // The read data registers hold their byte for as long as the result waits.
    assign rsp.valid       = res_valid;
    assign rsp.out_byte    = res.popped ? (res.from_tx ? tx_rdata : rx_rdata) : '0;
    assign rsp.out_valid   = res.popped;
    assign rsp.accepted    = res.accepted;
    assign rsp.rx_readable = res.rx_readable;
    assign rsp.tx_writable = res.tx_writable;
    assign rsp.lost_count  = res.lost_count;

endmodule
